FILE: rtl/mcpd_pkg.sv
// package for the multi-class priority deque
// sizes, field widths, status codes, controller states and command struct
// no dependencies
package mcpd_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int NUM_CLASSES = 32;

    localparam int KIND_W   = 1;
    localparam int CLS_W    = 5;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int META_W    = PTR_W + CNT_W;
    localparam int CLS_IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int SLOTS     = NUM_CLASSES * QUEUE_DEPTH;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int ENTRY_W   = TAG_W + 1;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = KIND_W;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = STATUS_W;

    localparam logic [KIND_W-1:0] KIND_ADD  = 1'b0;
    localparam logic [KIND_W-1:0] KIND_TAKE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_ADDED  = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_SERVED = 2'd2,
        STATUS_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic load_out;
    } dp_cmd_t;

endpackage

FILE: rtl/mcpd_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module mcpd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/mcpd_ctrl.sv
// handshake controller for the priority deque
// depends on mcpd_pkg
module mcpd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output mcpd_pkg::dp_cmd_t cmd
);

    import mcpd_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic        out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    s_tready      = 1'b1;
                    if (s_tvalid) begin
                        cmd.accept = 1'b1;
                        state_next = ST_LOOKUP;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: rtl/mcpd_datapath.sv
// datapath: item register, class state ram, entry ram, ring pointer math, result register
// depends on mcpd_pkg and mcpd_ram
module mcpd_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mcpd_pkg::dp_cmd_t               cmd,
    input  logic [mcpd_pkg::KIND_W-1:0]     s_kind,
    input  logic [mcpd_pkg::CLS_W-1:0]      s_class_id,
    input  logic                            s_urgent,
    input  logic [mcpd_pkg::TAG_W-1:0]      s_tag,
    output logic [mcpd_pkg::STATUS_W-1:0]   m_status,
    output logic [mcpd_pkg::TAG_W-1:0]      m_served_tag,
    output logic                            m_served_urgent,
    output logic [mcpd_pkg::COUNT_W-1:0]    m_class_count
);

    import mcpd_pkg::*;

    logic [KIND_W-1:0] kind_reg;
    logic [CLS_W-1:0]  cls_reg;
    logic              urgent_reg;
    logic [TAG_W-1:0]  tag_reg;

    logic [NUM_CLASSES-1:0] class_valid_reg;
    logic [CLS_IDX_W-1:0]   cls_idx;
    logic [CLS_IDX_W-1:0]   rd_cls_idx;
    logic [META_W-1:0]      meta_rd_data;
    logic [META_W-1:0]      meta_wr_data;
    logic                   meta_we;

    logic [ENTRY_W-1:0] entry_rd_data;
    logic [SLOT_W-1:0]  slot_addr;
    logic               entry_we;
    logic               entry_re;

    logic             in_range;
    logic             cls_valid;
    logic [PTR_W-1:0] head;
    logic [CNT_W-1:0] count;
    logic [PTR_W-1:0] head_dec;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W:0]   tail_sum;
    logic [PTR_W-1:0] tail_pos;
    logic [PTR_W-1:0] pos;
    logic [PTR_W-1:0] new_head;
    logic [CNT_W-1:0] new_count;
    logic [31:0]      count_wide;
    status_t          status_c;

    status_t          res_status_reg;
    logic [COUNT_W-1:0] res_count_reg;

    logic [STATUS_W-1:0] m_status_reg;
    logic [TAG_W-1:0]    m_served_tag_reg;
    logic                m_served_urgent_reg;
    logic [COUNT_W-1:0]  m_class_count_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg   <= s_kind;
            cls_reg    <= s_class_id;
            urgent_reg <= s_urgent;
            tag_reg    <= s_tag;
        end
    end

    assign rd_cls_idx = CLS_IDX_W'(s_class_id);
    assign cls_idx    = CLS_IDX_W'(cls_reg);

    mcpd_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_CLASSES)
    ) u_meta_ram (
        .aclk    (aclk),
        .wr_en   (meta_we),
        .wr_addr (cls_idx),
        .wr_data (meta_wr_data),
        .rd_en   (cmd.accept),
        .rd_addr (rd_cls_idx),
        .rd_data (meta_rd_data)
    );

    mcpd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (entry_we),
        .wr_addr (slot_addr),
        .wr_data ({urgent_reg, tag_reg}),
        .rd_en   (entry_re),
        .rd_addr (slot_addr),
        .rd_data (entry_rd_data)
    );

    // class state reads as zero until first written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            class_valid_reg <= '0;
        end else if (meta_we) begin
            class_valid_reg[cls_idx] <= 1'b1;
        end
    end

    assign in_range  = (32'(cls_reg) < NUM_CLASSES);
    assign cls_valid = class_valid_reg[cls_idx];
    assign head      = cls_valid ? meta_rd_data[PTR_W-1:0] : '0;
    assign count     = cls_valid ? meta_rd_data[META_W-1:PTR_W] : '0;

    assign head_dec = (head == '0) ? PTR_W'(QUEUE_DEPTH - 1) : head - PTR_W'(1);
    assign head_inc = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + PTR_W'(1);
    assign tail_sum = {1'b0, head} + (PTR_W + 1)'(count);
    assign tail_pos = (tail_sum >= (PTR_W + 1)'(QUEUE_DEPTH))
                    ? PTR_W'(tail_sum - (PTR_W + 1)'(QUEUE_DEPTH))
                    : tail_sum[PTR_W-1:0];

    always_comb begin
        status_c  = STATUS_FULL;
        new_head  = head;
        new_count = count;
        pos       = head;
        meta_we   = 1'b0;
        entry_we  = 1'b0;
        entry_re  = 1'b0;
        if (!in_range) begin
            status_c  = (kind_reg == KIND_TAKE) ? STATUS_EMPTY : STATUS_FULL;
            new_count = '0;
        end else if (kind_reg == KIND_ADD) begin
            if (count >= CNT_W'(QUEUE_DEPTH)) begin
                status_c = STATUS_FULL;
            end else begin
                status_c  = STATUS_ADDED;
                new_head  = urgent_reg ? head_dec : head;
                pos       = urgent_reg ? head_dec : tail_pos;
                new_count = count + CNT_W'(1);
                meta_we   = cmd.lookup;
                entry_we  = cmd.lookup;
            end
        end else begin
            if (count == '0) begin
                status_c = STATUS_EMPTY;
            end else begin
                status_c  = STATUS_SERVED;
                new_head  = head_inc;
                new_count = count - CNT_W'(1);
                meta_we   = cmd.lookup;
                entry_re  = cmd.lookup;
            end
        end
    end

    assign meta_wr_data = {new_count, new_head};
    assign slot_addr    = SLOT_W'(32'(cls_reg) * QUEUE_DEPTH + 32'(pos));
    assign count_wide   = 32'(new_count);

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            res_status_reg <= status_c;
            res_count_reg  <= count_wide[COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status_reg      <= res_status_reg;
            m_class_count_reg <= res_count_reg;
            if (res_status_reg == STATUS_SERVED) begin
                m_served_tag_reg    <= entry_rd_data[TAG_W-1:0];
                m_served_urgent_reg <= entry_rd_data[TAG_W];
            end else begin
                m_served_tag_reg    <= '0;
                m_served_urgent_reg <= 1'b0;
            end
        end
    end

    assign m_status        = m_status_reg;
    assign m_served_tag    = m_served_tag_reg;
    assign m_served_urgent = m_served_urgent_reg;
    assign m_class_count   = m_class_count_reg;

endmodule

FILE: rtl/multi_class_priority_deque_top.sv
// channel   dir  tdata (low bit up)                      tuser
// s_        in   class_id[4:0] urgent[5] tag[21:6]       kind[0]
// m_        out  served_tag[15:0] served_urgent[16]      status[1:0]
//                class_count[20:17]
//
// each item takes an accept step that reads the class state ram and a lookup
// step that writes it back and reads or writes the entry ram
// from idle, an accepted item's result word is loaded in the result step after lookup
// reset clears the class state valid bits directly, no clearing pass
// while a result word waits on m_tready the block holds in its result step
// depends on mcpd_pkg, mcpd_ctrl, mcpd_datapath
module multi_class_priority_deque_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mcpd_pkg::S_TDATA_W-1:0]   s_tdata,  // class_id, urgent, tag
    input  logic [mcpd_pkg::S_TUSER_W-1:0]   s_tuser,  // kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mcpd_pkg::M_TDATA_W-1:0]   m_tdata,  // served_tag, served_urgent, class_count
    output logic [mcpd_pkg::M_TUSER_W-1:0]   m_tuser   // status
);

    import mcpd_pkg::*;

    dp_cmd_t             cmd;
    logic [TAG_W-1:0]    served_tag;
    logic                served_urgent;
    logic [COUNT_W-1:0]  class_count;
    logic [STATUS_W-1:0] status;

    mcpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    mcpd_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .s_kind          (s_tuser[KIND_W-1:0]),
        .s_class_id      (s_tdata[CLS_W-1:0]),
        .s_urgent        (s_tdata[CLS_W]),
        .s_tag           (s_tdata[CLS_W+TAG_W:CLS_W+1]),
        .m_status        (status),
        .m_served_tag    (served_tag),
        .m_served_urgent (served_urgent),
        .m_class_count   (class_count)
    );

    assign m_tdata = {{(M_TDATA_W - TAG_W - 1 - COUNT_W){1'b0}},
                      class_count, served_urgent, served_tag};
    assign m_tuser = status;

endmodule

FILE: rtl/mcpd_checker.sv
// port-level checks for the priority deque, bound to the top level
// depends on mcpd_pkg and multi_class_priority_deque_top
module mcpd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [mcpd_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [mcpd_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mcpd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [mcpd_pkg::M_TUSER_W-1:0] m_tuser
);

    import mcpd_pkg::*;

    logic [M_TUSER_W-1:0] served_code;
    logic [M_TUSER_W-1:0] empty_code;

    assign served_code = STATUS_SERVED;
    assign empty_code  = STATUS_EMPTY;

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken during lookup");

    a_unserved_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != served_code |-> m_tdata[TAG_W:0] == '0)
        else $error("served fields set without a served entry");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == empty_code |-> m_tdata[TAG_W+COUNT_W:TAG_W+1] == '0)
        else $error("empty class reports nonzero count");

endmodule

bind multi_class_priority_deque_top mcpd_checker u_mcpd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: dv/testbench.sv
// self-checking testbench for multi_class_priority_deque_top: a scoreboard class
// mirrors the per-class rings and checks every result word in order
// depends on mcpd_pkg and the rtl below multi_class_priority_deque_top
module testbench;
    import mcpd_pkg::*;

    typedef struct packed {
        status_t                status;
        logic [TAG_W-1:0]       tag;
        logic                   urgent;
        logic [COUNT_W-1:0]     count;
    } deque_result_t;

    class deque_scoreboard;
        logic [TAG_W-1:0] slot_tag [NUM_CLASSES][QUEUE_DEPTH];
        logic             slot_urgent [NUM_CLASSES][QUEUE_DEPTH];
        int               fill [NUM_CLASSES];
        int               head [NUM_CLASSES];
        deque_result_t    expected_words[$];
        int               errors;
        int               words_in;
        int               words_out;
        int               n_added;
        int               n_full;
        int               n_served;
        int               n_empty;

        function new();
            errors = 0;
            words_in = 0;
            words_out = 0;
            n_added = 0;
            n_full = 0;
            n_served = 0;
            n_empty = 0;
            foreach (fill[c]) begin
                fill[c] = 0;
                head[c] = 0;
            end
        endfunction

        function void note_word(logic [KIND_W-1:0] kind, logic [CLS_W-1:0] cls,
                                logic urg, logic [TAG_W-1:0] tag);
            deque_result_t r;
            int            pos;
            r = '{status: STATUS_ADDED, tag: '0, urgent: 1'b0, count: '0};
            words_in++;
            if (int'(cls) >= NUM_CLASSES) begin
                r.status = (kind == KIND_TAKE) ? STATUS_EMPTY : STATUS_FULL;
            end else if (kind == KIND_ADD) begin
                if (fill[cls] >= QUEUE_DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    if (urg) begin
                        head[cls] = (head[cls] + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                        pos = head[cls];
                    end else begin
                        pos = (head[cls] + fill[cls]) % QUEUE_DEPTH;
                    end
                    slot_tag[cls][pos] = tag;
                    slot_urgent[cls][pos] = urg;
                    fill[cls]++;
                    r.status = STATUS_ADDED;
                end
                r.count = fill[cls][COUNT_W-1:0];
            end else begin
                if (fill[cls] == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    r.status = STATUS_SERVED;
                    r.tag = slot_tag[cls][head[cls]];
                    r.urgent = slot_urgent[cls][head[cls]];
                    head[cls] = (head[cls] + 1) % QUEUE_DEPTH;
                    fill[cls]--;
                end
                r.count = fill[cls][COUNT_W-1:0];
            end
            expected_words.push_back(r);
        endfunction

        function void check_word(deque_result_t got);
            deque_result_t want;
            words_out++;
            case (got.status)
                STATUS_ADDED:  n_added++;
                STATUS_FULL:   n_full++;
                STATUS_SERVED: n_served++;
                default:       n_empty++;
            endcase
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: unexpected result status=%0d tag=%h urg=%0d count=%0d",
                             got.status, got.tag, got.urgent, got.count);
                return;
            end
            want = expected_words.pop_front();
            if (got.status !== want.status || got.tag !== want.tag ||
                got.urgent !== want.urgent || got.count !== want.count) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch at result %0d: exp status=%0d tag=%h urg=%0d count=%0d, %s",
                             words_out, want.status, want.tag, want.urgent, want.count,
                             $sformatf("got status=%0d tag=%h urg=%0d count=%0d",
                                       got.status, got.tag, got.urgent, got.count));
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    deque_scoreboard sb = new();
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_cycles_left = 0;

    multi_class_priority_deque_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off when requested
    initial begin
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_cycles_left > 0) begin
                m_tready <= 1'b0;
                hold_cycles_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // result monitor
    initial begin
        deque_result_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.status = status_t'(m_tuser);
                got.tag = m_tdata[15:0];
                got.urgent = m_tdata[16];
                got.count = m_tdata[20:17];
                sb.check_word(got);
            end
        end
    end

    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [CLS_W-1:0] cls,
                             input logic urg, input logic [TAG_W-1:0] tag);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, tag, urg, cls};
        s_tuser <= kind;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(kind, cls, urg, tag);
    endtask

    // bursts lean toward adds or takes on a few busy classes so rings fill and drain
    task automatic send_random(input int n);
        int                hot [4];
        int                add_pct;
        logic [CLS_W-1:0]  cls;
        foreach (hot[j]) hot[j] = $urandom_range(NUM_CLASSES - 1);
        add_pct = 50;
        for (int i = 0; i < n; i++) begin
            if (i % 24 == 0)
                add_pct = ((i / 24) % 3 == 0) ? 85 : (((i / 24) % 3 == 1) ? 20 : 55);
            if ($urandom_range(3) == 0)
                cls = CLS_W'($urandom_range(NUM_CLASSES - 1));
            else
                cls = CLS_W'(hot[$urandom_range(3)]);
            send_word(($urandom_range(99) < add_pct) ? KIND_ADD : KIND_TAKE, cls,
                      1'($urandom_range(1)), TAG_W'($urandom_range(16'hFFFF)));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty take, tag extremes, fill to full, reject, drain past empty, last class
        send_word(KIND_TAKE, 5'd0, 1'b0, 16'h1234);
        send_word(KIND_ADD, 5'd0, 1'b0, 16'h0000);
        send_word(KIND_ADD, 5'd0, 1'b1, 16'hFFFF);
        for (int i = 2; i < QUEUE_DEPTH; i++)
            send_word(KIND_ADD, 5'd0, i[0], 16'(i * 16'h1111));
        send_word(KIND_ADD, 5'd0, 1'b0, 16'hDEAD);
        send_word(KIND_ADD, 5'd0, 1'b1, 16'hBEEF);
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            send_word(KIND_TAKE, 5'd0, 1'b0, 16'h0000);
        send_word(KIND_ADD, 5'd31, 1'b1, 16'hA5A5);
        send_word(KIND_TAKE, 5'd31, 1'b0, 16'hFFFF);

        // receiver holds off while the sender keeps offering
        hold_cycles_left = 300;
        send_random(300);

        src_idle_pct = 64;
        send_random(280);
        src_idle_pct = 0;
        sink_stall_pct = 64;
        send_random(280);
        src_idle_pct = 16;
        sink_stall_pct = 16;
        send_random(290);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d words: %0d added, %0d rejected full, %0d served, %0d empty",
                 sb.words_in, sb.n_added, sb.n_full, sb.n_served, sb.n_empty);
        $display("idle mixes on both sides and one long receiver hold-off; %0d mismatches",
                 sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("testbench: FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/mcpd_pkg.sv
rtl/mcpd_ram.sv
rtl/mcpd_ctrl.sv
rtl/mcpd_datapath.sv
rtl/multi_class_priority_deque_top.sv
rtl/mcpd_checker.sv
dv/testbench.sv
